// File: rtl/pvtli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pvtli_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int PC_W = 5;
	localparam int CMP_W = (CNT_W > PC_W) ? CNT_W : PC_W;
	localparam int DATA_W = 32;
	localparam int STEP_W = $clog2(DATA_W);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] pressure;
		logic [DATA_W-1:0] fvf;
		logic [DATA_W-1:0] weight;
		logic [DATA_W-1:0] viscosity;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIRST,
		S_LAST,
		S_SCAN,
		S_SEG,
		S_WAIT,
		S_OUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		L_IDLE,
		L_MUL,
		L_DIV,
		L_FIX
	} lerp_state_t;

endpackage

`default_nettype wire

// File: rtl/pvt_table_linear_interpolator_core.sv
// Channel   Handshake               Payload
// in        in_valid / in_ready     opcode, entry_index, entry_*, query_pressure
// out       out_valid / out_ready   fvf_out, weight_out, viscosity_out, out_of_range
// cfg       cfg_we                  cfg_wdata (point_count)
//
// Items are taken only when idle. A query outside the table or at the first point
// reads the first and last points and ends; an interpolating query scans the
// one-write, one-read port table RAM for the upper point, and unless the segment
// is flat, each of the three interpolation units does 32 radix-2 divide steps.
// Reset clears control state only; table entries are undefined until written.
// A new item is accepted while a result waits; a query then holds in its last
// step until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module pvt_table_linear_interpolator_core
	import pvtli_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [PC_W-1:0]    cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               opcode,
	input  wire logic [3:0]         entry_index,
	input  wire logic [31:0]        entry_pressure,
	input  wire logic signed [31:0] entry_fvf,
	input  wire logic signed [31:0] entry_weight,
	input  wire logic signed [31:0] entry_viscosity,
	input  wire logic [31:0]        query_pressure,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      fvf_out,
	output logic signed [31:0]      weight_out,
	output logic signed [31:0]      viscosity_out,
	output logic                    out_of_range
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	logic [PC_W-1:0]   point_count_q;
	logic [CMP_W-1:0]  n_eff;
	logic [IDX_W-1:0]  last_idx;

	logic              in_xfer;
	logic              wr_en;
	entry_t            wr_data;
	logic [IDX_W-1:0]  rd_addr;
	entry_t            rd_data;

	logic [DATA_W-1:0] q_q;
	entry_t            lo_q;
	entry_t            hi_q;
	logic [IDX_W-1:0]  idx_q;

	logic [DATA_W-1:0] res_fvf_q;
	logic [DATA_W-1:0] res_weight_q;
	logic [DATA_W-1:0] res_visc_q;
	logic              res_oor_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_fvf_q;
	logic [DATA_W-1:0] out_weight_q;
	logic [DATA_W-1:0] out_visc_q;
	logic              out_oor_q;
	logic              out_free;

	logic              oor;
	logic              at_first;
	logic              scan_more;
	logic              flat_seg;
	logic              lerp_start;
	logic [DATA_W-1:0] seg_dq;
	logic [DATA_W-1:0] seg_dp;
	logic              done_fvf;
	logic              done_weight;
	logic              done_visc;
	logic              lerp_done;
	logic [DATA_W-1:0] lerp_fvf;
	logic [DATA_W-1:0] lerp_weight;
	logic [DATA_W-1:0] lerp_visc;

	always_comb begin
		n_eff = CMP_W'(point_count_q);
		if (n_eff < CMP_W'(2)) begin
			n_eff = CMP_W'(2);
		end
		if (n_eff > CMP_W'(TABLE_DEPTH)) begin
			n_eff = CMP_W'(TABLE_DEPTH);
		end
		last_idx = IDX_W'(n_eff - CMP_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= PC_W'(2);
		end else if (cfg_we) begin
			point_count_q <= cfg_wdata;
		end
	end

	assign in_xfer = in_valid && in_ready;
	assign wr_en = in_xfer && (opcode == OP_WRITE) && (32'(entry_index) < 32'(TABLE_DEPTH));
	assign wr_data = '{pressure: entry_pressure, fvf: entry_fvf, weight: entry_weight,
		viscosity: entry_viscosity};

	pvtli_ram u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (IDX_W'(entry_index)),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign oor = (q_q < lo_q.pressure) || (q_q > rd_data.pressure);
	assign at_first = !(q_q > lo_q.pressure);
	assign scan_more = (idx_q < last_idx) && (q_q > rd_data.pressure);
	assign flat_seg = (hi_q.pressure <= lo_q.pressure);
	assign seg_dq = q_q - lo_q.pressure;
	assign seg_dp = hi_q.pressure - lo_q.pressure;
	assign out_free = !out_valid_q || out_ready;
	assign lerp_done = done_fvf && done_weight && done_visc;

	always_comb begin
		state_d = state_q;
		rd_addr = '0;
		in_ready = 1'b0;
		lerp_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (opcode == OP_QUERY)) begin
					state_d = S_FIRST;
				end
			end
			S_FIRST: begin
				rd_addr = last_idx;
				state_d = S_LAST;
			end
			S_LAST: begin
				rd_addr = IDX_W'(1);
				if (oor || at_first) begin
					state_d = S_OUT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_more) begin
					rd_addr = idx_q + IDX_W'(1);
				end else begin
					state_d = S_SEG;
				end
			end
			S_SEG: begin
				if (flat_seg) begin
					state_d = S_OUT;
				end else begin
					lerp_start = 1'b1;
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				if (lerp_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					q_q <= query_pressure;
				end
			end
			S_FIRST: begin
				lo_q <= rd_data;
			end
			S_LAST: begin
				idx_q <= IDX_W'(1);
				res_oor_q <= oor;
				if (oor) begin
					res_fvf_q <= '0;
					res_weight_q <= '0;
					res_visc_q <= '0;
				end else begin
					res_fvf_q <= lo_q.fvf;
					res_weight_q <= lo_q.weight;
					res_visc_q <= lo_q.viscosity;
				end
			end
			S_SCAN: begin
				if (scan_more) begin
					lo_q <= rd_data;
					idx_q <= idx_q + IDX_W'(1);
				end else begin
					hi_q <= rd_data;
				end
			end
			S_SEG: begin
				res_oor_q <= 1'b0;
				res_fvf_q <= lo_q.fvf;
				res_weight_q <= lo_q.weight;
				res_visc_q <= lo_q.viscosity;
			end
			S_WAIT: begin
				if (lerp_done) begin
					res_fvf_q <= lerp_fvf;
					res_weight_q <= lerp_weight;
					res_visc_q <= lerp_visc;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_fvf_q <= res_fvf_q;
					out_weight_q <= res_weight_q;
					out_visc_q <= res_visc_q;
					out_oor_q <= res_oor_q;
				end
			end
			default: begin
				q_q <= q_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	pvtli_lerp u_lerp_fvf (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lerp_start),
		.lo     (lo_q.fvf),
		.hi     (hi_q.fvf),
		.dq     (seg_dq),
		.dp     (seg_dp),
		.done   (done_fvf),
		.result (lerp_fvf)
	);

	pvtli_lerp u_lerp_weight (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lerp_start),
		.lo     (lo_q.weight),
		.hi     (hi_q.weight),
		.dq     (seg_dq),
		.dp     (seg_dp),
		.done   (done_weight),
		.result (lerp_weight)
	);

	pvtli_lerp u_lerp_visc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lerp_start),
		.lo     (lo_q.viscosity),
		.hi     (hi_q.viscosity),
		.dq     (seg_dq),
		.dp     (seg_dp),
		.done   (done_visc),
		.result (lerp_visc)
	);

	assign out_valid = out_valid_q;
	assign fvf_out = $signed(out_fvf_q);
	assign weight_out = $signed(out_weight_q);
	assign viscosity_out = $signed(out_visc_q);
	assign out_of_range = out_oor_q;

endmodule

`default_nettype wire

// File: rtl/pvtli_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pvtli_ram
	import pvtli_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire entry_t           wdata,
	input  wire logic [IDX_W-1:0] raddr,
	output entry_t                rdata
);

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/pvtli_lerp.sv
`timescale 1ns / 1ps
`default_nettype none

module pvtli_lerp
	import pvtli_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DATA_W-1:0] lo,
	input  wire logic [DATA_W-1:0] hi,
	input  wire logic [DATA_W-1:0] dq,
	input  wire logic [DATA_W-1:0] dp,
	output logic                   done,
	output logic [DATA_W-1:0]      result
);

	lerp_state_t state_q;
	lerp_state_t state_d;
	logic [STEP_W-1:0] step_q;
	logic done_q;

	logic [DATA_W-1:0] lo_q;
	logic [DATA_W-1:0] mag_q;
	logic [DATA_W-1:0] dq_q;
	logic [DATA_W-1:0] dp_q;
	logic              neg_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] res_q;

	logic signed [DATA_W:0] lo_ext;
	logic signed [DATA_W:0] hi_ext;
	logic signed [DATA_W:0] diff_up;
	logic signed [DATA_W:0] diff_dn;
	logic [2*DATA_W-1:0]    prod;
	logic [DATA_W:0]        trial;
	logic [DATA_W:0]        trial_sub;
	logic                   take;

	always_comb begin
		lo_ext = $signed({lo[DATA_W-1], lo});
		hi_ext = $signed({hi[DATA_W-1], hi});
		diff_up = hi_ext - lo_ext;
		diff_dn = lo_ext - hi_ext;
		prod = mag_q * dq_q;
		trial = {rem_q, quo_q[DATA_W-1]};
		trial_sub = trial - {1'b0, dp_q};
		take = (trial >= {1'b0, dp_q});
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			L_IDLE: begin
				if (start) begin
					state_d = L_MUL;
				end
			end
			L_MUL: begin
				state_d = L_DIV;
			end
			L_DIV: begin
				if (step_q == STEP_W'(DATA_W - 1)) begin
					state_d = L_FIX;
				end
			end
			L_FIX: begin
				state_d = L_IDLE;
			end
			default: begin
				state_d = L_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == L_FIX);
			if (state_q == L_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (start) begin
					lo_q <= lo;
					dq_q <= dq;
					dp_q <= dp;
					neg_q <= diff_up[DATA_W];
					mag_q <= diff_up[DATA_W] ? diff_dn[DATA_W-1:0] : diff_up[DATA_W-1:0];
				end
			end
			L_MUL: begin
				rem_q <= prod[2*DATA_W-1:DATA_W];
				quo_q <= prod[DATA_W-1:0];
			end
			L_DIV: begin
				rem_q <= take ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], take};
			end
			L_FIX: begin
				res_q <= neg_q ? (lo_q - quo_q) : (lo_q + quo_q);
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign done = done_q;
	assign result = res_q;

endmodule

`default_nettype wire
